// ----- design/csr_sparse_matrix_vector_multiply_defines.svh -----
// Assertion macros used by the sparse matrix-vector multiply back end.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define CSRMV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define CSRMV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/csrmv_pkg.sv -----
// Shared types and constants for the sparse matrix-vector multiply block.
package csrmv_pkg;

    // Default sizes of the matrix in use.
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 65536;

    // Fixed field widths: Q16.16 operands and a Q32.32 row sum.
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;

    // Queue depths between the parts of the block.
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

    // Saturation limits of the row sum.
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Classification of one nonzero, made by the front end.
    typedef struct packed {
        logic close_prev;
        logic final_entry;
        logic col_ok;
    } item_ctl_t;

    // Status flags that travel with one row result.
    typedef struct packed {
        logic last;
        logic saturated;
        logic bad_column;
    } res_flags_t;

endpackage

// ----- design/csrmv_fifo.sv -----
// Small synchronous queue built from registers, one push and one pop per cycle.
module csrmv_fifo #(
    parameter int WIDTH = csrmv_pkg::VALUE_W,
    parameter int DEPTH = csrmv_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- design/csrmv_front.sv -----
// Front end: accepts transactions, holds the vector store and classifies nonzeros.
module csrmv_front #(
    parameter int MAX_COLS = csrmv_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = csrmv_pkg::DEF_MAX_ROWS,
    localparam int COL_W  = $clog2(MAX_COLS),
    localparam int NCOL_W = $clog2(MAX_COLS + 1),
    localparam int ROW_W  = $clog2(MAX_ROWS)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   kind,
    input  logic [COL_W-1:0]                       column,
    input  logic [ROW_W-1:0]                       entry_row,
    input  logic signed [csrmv_pkg::VALUE_W-1:0]   value,
    input  logic                                   final_entry,
    input  logic [NCOL_W-1:0]                      num_cols,
    output logic                                   q_push,
    input  logic                                   q_full,
    output csrmv_pkg::item_ctl_t                   q_ctl,
    output logic [ROW_W-1:0]                       q_row,
    output logic [csrmv_pkg::VALUE_W-1:0]          q_value,
    output logic [csrmv_pkg::VALUE_W-1:0]          q_vec
);

    logic [csrmv_pkg::VALUE_W-1:0] vec_mem [MAX_COLS];
    logic [csrmv_pkg::VALUE_W-1:0] rd_data_reg;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    csrmv_pkg::item_ctl_t          s1_ctl_reg;
    logic [ROW_W-1:0]              s1_row_reg;
    logic [csrmv_pkg::VALUE_W-1:0] s1_value_reg;

    logic                          row_open_reg;
    logic                          row_open_next;
    logic [ROW_W-1:0]              cur_row_reg;
    logic [ROW_W-1:0]              cur_row_next;

    logic                          accept;
    logic                          acc_load;
    logic                          acc_nz;
    logic                          col_ok;
    csrmv_pkg::item_ctl_t          ctl;

    // Input handshake: only a held item waiting on a full queue stalls the input.
    assign in_stall = s1_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign acc_load = accept && !kind;
    assign acc_nz   = accept && kind;

    // Column range check against the configured width and the store depth.
    assign col_ok = (NCOL_W'(column) < num_cols) && (32'(column) < 32'(MAX_COLS));

    // Classification of a nonzero against the row that is open.
    always_comb
    begin
        ctl.close_prev  = row_open_reg && (entry_row != cur_row_reg);
        ctl.final_entry = final_entry;
        ctl.col_ok      = col_ok;
    end

    // Row tracking and the hand-off register.
    always_comb
    begin
        row_open_next = row_open_reg;
        cur_row_next  = cur_row_reg;
        s1_valid_next = s1_valid_reg;
        if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
        if (acc_nz)
        begin
            row_open_next = !final_entry;
            cur_row_next  = entry_row;
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_open_reg <= 1'b0;
            cur_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_open_reg <= row_open_next;
            cur_row_reg  <= cur_row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload of the classified nonzero.
    always_ff @(posedge clk)
    begin
        if (acc_nz)
        begin
            s1_ctl_reg   <= ctl;
            s1_row_reg   <= entry_row;
            s1_value_reg <= value;
        end
    end

    // Vector store: loads write, nonzeros read, both in arrival order.
    always_ff @(posedge clk)
    begin
        if (acc_load && col_ok)
        begin
            vec_mem[column] <= value;
        end
        if (acc_nz && col_ok)
        begin
            rd_data_reg <= vec_mem[column];
        end
    end

    assign q_push  = s1_valid_reg && !q_full;
    assign q_ctl   = s1_ctl_reg;
    assign q_row   = s1_row_reg;
    assign q_value = s1_value_reg;
    assign q_vec   = rd_data_reg;

endmodule

// ----- design/csrmv_back.sv -----
// Back end: multiplies each nonzero, accumulates with saturation and closes rows.
`include "csr_sparse_matrix_vector_multiply_defines.svh"

module csrmv_back #(
    parameter int MAX_ROWS = csrmv_pkg::DEF_MAX_ROWS,
    localparam int ROW_W = $clog2(MAX_ROWS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    output logic                                 q_pop,
    input  csrmv_pkg::item_ctl_t                 q_ctl,
    input  logic [ROW_W-1:0]                     q_row,
    input  logic [csrmv_pkg::VALUE_W-1:0]        q_value,
    input  logic [csrmv_pkg::VALUE_W-1:0]        q_vec,
    output logic                                 o_push,
    input  logic                                 o_full,
    output logic [ROW_W-1:0]                     o_row,
    output logic [csrmv_pkg::SUM_W-1:0]          o_sum,
    output csrmv_pkg::res_flags_t                o_flags
);

    localparam int SUM_W = csrmv_pkg::SUM_W;

    // Multiply stage.
    logic                  m_valid_reg;
    logic                  m_valid_next;
    csrmv_pkg::item_ctl_t  m_ctl_reg;
    logic [ROW_W-1:0]      m_row_reg;
    logic [SUM_W-1:0]      m_prod_reg;
    logic signed [SUM_W-1:0] prod;

    // Accumulate stage state.
    logic [SUM_W-1:0]      acc_reg;
    logic [SUM_W-1:0]      acc_next;
    logic                  sat_reg;
    logic                  sat_next;
    logic                  bad_reg;
    logic                  bad_next;
    logic [ROW_W-1:0]      cur_row_reg;
    logic [ROW_W-1:0]      cur_row_next;
    logic                  phase_reg;
    logic                  phase_next;

    logic                  m_ready;
    logic                  close_pend;
    logic                  emit;
    logic                  fire;
    logic                  m_done;
    logic [SUM_W-1:0]      base;
    logic [SUM_W-1:0]      addend;
    logic [SUM_W-1:0]      sum;
    logic                  ovf;
    logic [SUM_W-1:0]      new_acc;
    logic                  new_sat;
    logic                  new_bad;

    // Signed 32 by 32 product, registered before the accumulator.
    assign prod = $signed(q_value) * $signed(q_vec);

    // A row change closes the old row first; with a final nonzero the item
    // then needs a second phase to deliver its own result.
    assign close_pend = m_valid_reg && m_ctl_reg.close_prev && !phase_reg;
    assign emit       = m_valid_reg && (close_pend || m_ctl_reg.final_entry);
    assign fire       = m_valid_reg && (!emit || !o_full);
    assign m_done     = fire && !(close_pend && m_ctl_reg.final_entry);
    assign m_ready    = !m_valid_reg || m_done;
    assign q_pop      = q_valid && m_ready;

    // Saturating add of the product to the running sum.
    always_comb
    begin
        base    = close_pend ? '0 : acc_reg;
        addend  = (phase_reg || !m_ctl_reg.col_ok) ? '0 : m_prod_reg;
        sum     = base + addend;
        ovf     = (base[SUM_W-1] == addend[SUM_W-1]) && (sum[SUM_W-1] != base[SUM_W-1]);
        new_acc = ovf ? (base[SUM_W-1] ? csrmv_pkg::SUM_MIN : csrmv_pkg::SUM_MAX) : sum;
        new_sat = (close_pend ? 1'b0 : sat_reg) || ovf;
        new_bad = (close_pend ? 1'b0 : bad_reg) || (!phase_reg && !m_ctl_reg.col_ok);
    end

    // Result selection: the closed row, or the row ended by a final nonzero.
    always_comb
    begin
        o_push = emit && fire;
        if (close_pend)
        begin
            o_row              = cur_row_reg;
            o_sum              = acc_reg;
            o_flags.last       = 1'b0;
            o_flags.saturated  = sat_reg;
            o_flags.bad_column = bad_reg;
        end
        else
        begin
            o_row              = m_row_reg;
            o_sum              = new_acc;
            o_flags.last       = 1'b1;
            o_flags.saturated  = new_sat;
            o_flags.bad_column = new_bad;
        end
    end

    // Accumulator, row flags and phase update.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        acc_next     = acc_reg;
        sat_next     = sat_reg;
        bad_next     = bad_reg;
        cur_row_next = cur_row_reg;
        phase_next   = phase_reg;
        if (m_done)
        begin
            m_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            m_valid_next = 1'b1;
        end
        if (fire)
        begin
            cur_row_next = m_row_reg;
            if (m_ctl_reg.final_entry && !close_pend)
            begin
                acc_next   = '0;
                sat_next   = 1'b0;
                bad_next   = 1'b0;
                phase_next = 1'b0;
            end
            else
            begin
                acc_next   = new_acc;
                sat_next   = new_sat;
                bad_next   = new_bad;
                phase_next = close_pend && m_ctl_reg.final_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            bad_reg     <= 1'b0;
            cur_row_reg <= '0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            sat_reg     <= sat_next;
            bad_reg     <= bad_next;
            cur_row_reg <= cur_row_next;
            phase_reg   <= phase_next;
        end
    end

    // Multiply stage payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_ctl_reg  <= q_ctl;
            m_row_reg  <= q_row;
            m_prod_reg <= prod;
        end
    end

    // The second phase only exists for a final nonzero that also changed the row.
    `CSRMV_ASSERT_IMP(a_phase_item, phase_reg,
        m_valid_reg && m_ctl_reg.final_entry && m_ctl_reg.close_prev,
        "second phase without a final row-changing nonzero")

    // A final nonzero leaves the accumulator and row flags clear.
    `CSRMV_ASSERT_NXT(a_final_clears, fire && m_ctl_reg.final_entry && !close_pend,
        acc_reg == '0 && !sat_reg && !bad_reg && !phase_reg,
        "row state not cleared after final nonzero")

    // A nonzero that cannot finish keeps its product and row.
    `CSRMV_ASSERT_NXT(a_hold_item, m_valid_reg && !m_done,
        m_valid_reg && $stable(m_prod_reg) && $stable(m_row_reg),
        "blocked nonzero changed in the multiply stage")

endmodule

// ----- design/csr_sparse_matrix_vector_multiply.sv -----
// Sparse matrix (row-major nonzero stream) times dense vector, Q16.16 in, Q32.32 out.
// The block takes one input transaction per clock while in_stall is low: vector loads
// write the store, and each nonzero reads its vector element, is multiplied in one
// registered 32 by 32 multiplier and added to the row sum in one 64-bit saturating
// adder. A row result comes out when the row index changes and on the nonzero marked
// final; rows with no nonzeros give nothing. A nonzero that both changes the row and
// is final delivers two result transactions and holds the accumulate stage for a
// second phase, as the output queue takes one result per cycle. A result is offered
// once its closing nonzero has passed the store read, the item queue, the multiply
// stage and the accumulate stage into the output queue. The vector store is not
// cleared at reset: read only elements you loaded.
// Configuration writes are taken at any time but must only be made while idle.
module csr_sparse_matrix_vector_multiply #(
    parameter int MAX_COLS = csrmv_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = csrmv_pkg::DEF_MAX_ROWS,
    localparam int COL_W  = $clog2(MAX_COLS),
    localparam int NCOL_W = $clog2(MAX_COLS + 1),
    localparam int ROW_W  = $clog2(MAX_ROWS),
    localparam int CFG_W  = (ROW_W + 1 > NCOL_W) ? ROW_W + 1 : NCOL_W
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [csrmv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]                       cfg_data,
    // Input channel.
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   kind,
    input  logic [COL_W-1:0]                       column,
    input  logic [ROW_W-1:0]                       entry_row,
    input  logic signed [csrmv_pkg::VALUE_W-1:0]   value,
    input  logic                                   final_entry,
    // Result channel.
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ROW_W-1:0]                       out_row,
    output logic signed [csrmv_pkg::SUM_W-1:0]     row_sum,
    output logic                                   last,
    output logic                                   saturated,
    output logic                                   bad_column
);

    localparam int CTL_W = $bits(csrmv_pkg::item_ctl_t);
    localparam int FLG_W = $bits(csrmv_pkg::res_flags_t);
    localparam int QW    = CTL_W + ROW_W + 2 * csrmv_pkg::VALUE_W;
    localparam int OW    = ROW_W + csrmv_pkg::SUM_W + FLG_W;

    logic [NCOL_W-1:0]               num_cols_reg;
    logic [NCOL_W-1:0]               num_cols_next;

    logic                            q_push;
    logic                            q_full;
    logic                            q_empty;
    logic                            q_pop;
    csrmv_pkg::item_ctl_t            f_ctl;
    logic [ROW_W-1:0]                f_row;
    logic [csrmv_pkg::VALUE_W-1:0]   f_value;
    logic [csrmv_pkg::VALUE_W-1:0]   f_vec;
    logic [QW-1:0]                   q_din;
    logic [QW-1:0]                   q_dout;
    csrmv_pkg::item_ctl_t            b_ctl;
    logic [ROW_W-1:0]                b_row;
    logic [csrmv_pkg::VALUE_W-1:0]   b_value;
    logic [csrmv_pkg::VALUE_W-1:0]   b_vec;

    logic                            o_push;
    logic                            o_full;
    logic                            o_empty;
    logic                            o_pop;
    logic [ROW_W-1:0]                r_row;
    logic [csrmv_pkg::SUM_W-1:0]     r_sum;
    csrmv_pkg::res_flags_t           r_flags;
    logic [OW-1:0]                   o_din;
    logic [OW-1:0]                   o_dout;
    csrmv_pkg::res_flags_t           out_flags;

    // Configuration registers; the row count does not change any result.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        num_cols_next = num_cols_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                csrmv_pkg::CFG_NUM_ROWS: num_cols_next = num_cols_reg;
                csrmv_pkg::CFG_NUM_COLS: num_cols_next = cfg_data[NCOL_W-1:0];
                default:                 num_cols_next = num_cols_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= NCOL_W'(1);
        end
        else
        begin
            num_cols_reg <= num_cols_next;
        end
    end

    // Front end.
    csrmv_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .column      (column),
        .entry_row   (entry_row),
        .value       (value),
        .final_entry (final_entry),
        .num_cols    (num_cols_reg),
        .q_push      (q_push),
        .q_full      (q_full),
        .q_ctl       (f_ctl),
        .q_row       (f_row),
        .q_value     (f_value),
        .q_vec       (f_vec)
    );

    // Queue of classified nonzeros between front and back.
    assign q_din = {f_ctl, f_row, f_value, f_vec};

    csrmv_fifo #(
        .WIDTH (QW),
        .DEPTH (csrmv_pkg::QUEUE_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign {b_ctl, b_row, b_value, b_vec} = q_dout;

    // Back end.
    csrmv_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_empty),
        .q_pop   (q_pop),
        .q_ctl   (b_ctl),
        .q_row   (b_row),
        .q_value (b_value),
        .q_vec   (b_vec),
        .o_push  (o_push),
        .o_full  (o_full),
        .o_row   (r_row),
        .o_sum   (r_sum),
        .o_flags (r_flags)
    );

    // Output queue; its head drives the result channel.
    assign o_din = {r_row, r_sum, r_flags};
    assign o_pop = out_valid && !out_stall;

    csrmv_fifo #(
        .WIDTH (OW),
        .DEPTH (csrmv_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .din   (o_din),
        .pop   (o_pop),
        .dout  (o_dout),
        .full  (o_full),
        .empty (o_empty)
    );

    assign out_valid                   = !o_empty;
    assign {out_row, row_sum, out_flags} = o_dout;
    assign last                        = out_flags.last;
    assign saturated                   = out_flags.saturated;
    assign bad_column                  = out_flags.bad_column;

endmodule

// ----- sim/csr_sparse_matrix_vector_multiply_tb.sv -----
// Self-checking testbench for the streaming CSR sparse matrix-vector multiply block.
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_multiply_tb;
    import csrmv_pkg::*;

    localparam int COL_W = 10;
    localparam int ROW_W = 16;
    localparam int CFG_W = 17;
    localparam int NUM_COLS_MAX = 1024;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TIMEOUT_NS = 10_000_000;

    // Input kinds.
    localparam bit KIND_LOAD    = 1'b0;
    localparam bit KIND_NONZERO = 1'b1;

    // One expected row result.
    typedef struct {
        logic [ROW_W-1:0]         row;
        logic signed [SUM_W-1:0]  sum;
        bit                       last;
        bit                       sat;
        bit                       bad;
    } row_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic                        kind;
    logic [COL_W-1:0]            column;
    logic [ROW_W-1:0]            entry_row;
    logic signed [VALUE_W-1:0]   value;
    logic                        final_entry;
    logic                        out_valid;
    logic                        out_stall;
    logic [ROW_W-1:0]            out_row;
    logic signed [SUM_W-1:0]     row_sum;
    logic                        last;
    logic                        saturated;
    logic                        bad_column;

    // Shadow state of the block, kept in step with accepted transactions.
    logic signed [VALUE_W-1:0]   vec_shadow [NUM_COLS_MAX];
    bit                          vec_written [NUM_COLS_MAX];
    logic [10:0]                 cols_in_use;
    longint                      row_acc;
    logic [ROW_W-1:0]            open_row;
    bit                          row_is_open;
    bit                          acc_sat;
    bit                          acc_bad;
    row_result_t                 expected_rows [$];

    bit                          gaps_on;
    int unsigned                 items_sent;
    int unsigned                 rows_checked;
    int unsigned                 cfg_writes;
    int unsigned                 errors;

    csr_sparse_matrix_vector_multiply DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .column      (column),
        .entry_row   (entry_row),
        .value       (value),
        .final_entry (final_entry),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_row     (out_row),
        .row_sum     (row_sum),
        .last        (last),
        .saturated   (saturated),
        .bad_column  (bad_column)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("csr_sparse_matrix_vector_multiply_tb NOT OK");
        $finish;
    end

    // Random gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // Operand value with a bias toward the corners of Q16.16.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 15)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0001_0000;
            endcase
        end
        return $urandom;
    endfunction

    // Closes the open row and queues its expected result.
    function automatic void close_row(bit is_last);
        row_result_t r;
        r.row  = open_row;
        r.sum  = row_acc;
        r.last = is_last;
        r.sat  = acc_sat;
        r.bad  = acc_bad;
        expected_rows = {expected_rows, r};
        row_acc     = 0;
        acc_sat     = 1'b0;
        acc_bad     = 1'b0;
        row_is_open = 1'b0;
    endfunction

    // Applies one accepted input transaction to the shadow state.
    function automatic void accumulate_item(bit k, logic [COL_W-1:0] c,
                                            logic [ROW_W-1:0] r,
                                            logic signed [VALUE_W-1:0] v, bit f);
        longint prod;
        longint total;
        bit     col_ok;
        col_ok = c < cols_in_use;
        if (k == KIND_LOAD)
        begin
            if (col_ok)
            begin
                vec_shadow[c]  = v;
                vec_written[c] = 1'b1;
            end
            return;
        end
        if (row_is_open && r != open_row)
            close_row(1'b0);
        open_row    = r;
        row_is_open = 1'b1;
        if (col_ok)
        begin
            prod  = longint'(v) * longint'(vec_shadow[c]);
            total = row_acc + prod;
            // Signed overflow clips and flags; later terms add to the clipped sum.
            if (row_acc[63] == prod[63] && total[63] != row_acc[63])
            begin
                row_acc = row_acc[63] ? longint'(SUM_MIN) : longint'(SUM_MAX);
                acc_sat = 1'b1;
            end
            else
                row_acc = total;
        end
        else
            acc_bad = 1'b1;
        if (f)
            close_row(1'b1);
    endfunction

    // Sends one input transaction after a random gap and updates the shadow state.
    task automatic send_item(bit k, logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                             logic signed [VALUE_W-1:0] v, bit f);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        kind        <= k;
        column      <= c;
        entry_row   <= r;
        value       <= v;
        final_entry <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accumulate_item(k, c, r, v, f);
        items_sent++;
    endtask

    // Vector load; the row and final fields are don't-care and get random values.
    task automatic send_load(logic [COL_W-1:0] c, logic signed [VALUE_W-1:0] v);
        send_item(KIND_LOAD, c, ROW_W'($urandom), v, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_nonzero(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                logic signed [VALUE_W-1:0] v, bit f);
        send_item(KIND_NONZERO, c, r, v, f);
    endtask

    // Drops valid, waits for every expected result, then lets the pipeline empty.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One configuration register write.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_NUM_COLS)
            cols_in_use = data[10:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("ERROR at %0t: result %0d field %s is %h, expected %h",
                 $time, rows_checked, field, got, want);
        errors++;
    endtask

    // Result checker: every accepted result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        row_result_t exp_r;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_rows.size() == 0)
            begin
                $display("ERROR at %0t: result for row %0d with none expected",
                         $time, out_row);
                errors++;
            end
            else
            begin
                exp_r = expected_rows.pop_front();
                if (out_row !== exp_r.row)
                    report_mismatch("out_row", 64'(out_row), 64'(exp_r.row));
                if (row_sum !== exp_r.sum)
                    report_mismatch("row_sum", row_sum, exp_r.sum);
                if (last !== exp_r.last)
                    report_mismatch("last", 64'(last), 64'(exp_r.last));
                if (saturated !== exp_r.sat)
                    report_mismatch("saturated", 64'(saturated), 64'(exp_r.sat));
                if (bad_column !== exp_r.bad)
                    report_mismatch("bad_column", 64'(bad_column), 64'(exp_r.bad));
                rows_checked++;
            end
        end
    end

    // Result-side backpressure.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (gaps_on && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // Reset register values: one column, a bad column, a load that must be ignored.
    task automatic test_reset_config();
        gaps_on = 1'b1;
        send_load(10'd0, 32'h0001_8000);
        send_load(10'd1, 32'h1234_5678);
        send_nonzero(16'd3, 10'd0, 32'h0002_0000, 1'b0);
        send_nonzero(16'd3, 10'd1, 32'h0000_0001, 1'b1);
        drain_results();
    endtask

    // Widest settings, corner operands, both saturation directions, a row going down,
    // and a final nonzero that also changes the row.
    task automatic test_extreme_values();
        write_register(CFG_NUM_ROWS, 17'h1_0000);
        write_register(CFG_NUM_COLS, 17'd1024);
        send_load(10'd1023, 32'h7FFF_FFFF);
        send_load(10'd0, 32'h8000_0000);
        send_load(10'd512, 32'hFFFF_FFFF);
        repeat (3) send_nonzero(16'hFFFF, 10'd1023, 32'h7FFF_FFFF, 1'b0);
        send_nonzero(16'hFFFF, 10'd512, 32'h0000_0001, 1'b0);
        repeat (2) send_nonzero(16'd0, 10'd0, 32'h8000_0000, 1'b0);
        repeat (3) send_nonzero(16'd1, 10'd1023, 32'h8000_0000, 1'b0);
        send_nonzero(16'd1, 10'd512, 32'hFFFF_FFFF, 1'b0);
        send_nonzero(16'd2, 10'd0, 32'h7FFF_FFFF, 1'b1);
        drain_results();
    endtask

    // Single-nonzero final row, the same row reopened, a load in mid-row, a bad column.
    task automatic test_special_cases();
        write_register(CFG_NUM_ROWS, 17'd1);
        write_register(CFG_NUM_COLS, 17'd2);
        send_load(10'd1, 32'h0001_0000);
        send_nonzero(16'd5, 10'd0, 32'h0001_0000, 1'b1);
        send_nonzero(16'd5, 10'd1, 32'hFFFF_0000, 1'b0);
        send_load(10'd1, 32'h0003_0000);
        send_nonzero(16'd5, 10'd1, 32'h0001_0000, 1'b0);
        send_nonzero(16'd4, 10'd1000, $urandom, 1'b0);
        send_nonzero(16'd4, 10'd0, 32'h0000_0000, 1'b1);
        drain_results();
    endtask

    // Random matrices: vector loads, then row-major nonzeros with some noise mixed in.
    task automatic test_random_traffic();
        int unsigned      stop_at;
        int               legal_cols [$];
        int               big_col;
        int               n_loads;
        int               n_rows;
        int               n_nz;
        int               r;
        int               c;
        bit               sat_row;
        bit               fin;
        logic [ROW_W-1:0] row;
        logic signed [VALUE_W-1:0] sat_val;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            gaps_on = $urandom_range(0, 4) != 0;
            // New register settings now and then, always from an idle block.
            if (legal_cols.size() == 0 || $urandom_range(0, 99) < 30)
            begin
                drain_results();
                r = $urandom_range(0, 99);
                write_register(CFG_NUM_ROWS, r < 15 ? 17'd1 : r < 30 ? 17'h1_0000 :
                               17'($urandom_range(2, 65535)));
                r = $urandom_range(0, 99);
                write_register(CFG_NUM_COLS, r < 10 ? 17'd1 : r < 20 ? 17'd1024 :
                               r < 75 ? 17'($urandom_range(1, 16)) :
                               17'($urandom_range(17, 1023)));
            end
            legal_cols.delete();
            for (int i = 0; i < cols_in_use; i++)
                if (vec_written[i])
                    legal_cols = {legal_cols, i};

            // Vector loads, one of them perhaps a corner value for saturating rows.
            big_col = -1;
            n_loads = $urandom_range(1, cols_in_use < 10 ? cols_in_use : 10);
            for (int i = 0; i < n_loads; i++)
            begin
                c = $urandom_range(0, cols_in_use - 1);
                if (i == 0 && $urandom_range(0, 99) < 30)
                begin
                    send_load(COL_W'(c),
                              $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
                    big_col = c;
                end
                else
                    send_load(COL_W'(c), pick_value());
                legal_cols = {legal_cols, c};
            end
            if (cols_in_use < NUM_COLS_MAX && $urandom_range(0, 99) < 20)
                send_load(COL_W'($urandom_range(cols_in_use, NUM_COLS_MAX - 1)),
                          pick_value());

            // Rows of nonzeros; the last nonzero of the round is marked final.
            n_rows = $urandom_range(1, 6);
            row    = ROW_W'($urandom);
            for (int j = 0; j < n_rows; j++)
            begin
                sat_row = big_col >= 0 && $urandom_range(0, 99) < 15;
                sat_val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                n_nz    = sat_row ? $urandom_range(3, 5) : $urandom_range(1, 5);
                for (int k = 0; k < n_nz; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                    begin
                        c = $urandom_range(0, cols_in_use - 1);
                        send_load(COL_W'(c), pick_value());
                        legal_cols = {legal_cols, c};
                    end
                    else if (r < 8)
                    begin
                        c = $urandom_range(0, NUM_COLS_MAX - 1);
                        send_load(COL_W'(c), pick_value());
                        if (c < cols_in_use)
                            legal_cols = {legal_cols, c};
                    end
                    fin = (j == n_rows - 1 && k == n_nz - 1) || $urandom_range(0, 99) < 3;
                    if (sat_row)
                        send_nonzero(row, COL_W'(big_col), sat_val, fin);
                    else if (cols_in_use < NUM_COLS_MAX && $urandom_range(0, 99) < 8)
                        send_nonzero(row,
                                     COL_W'($urandom_range(cols_in_use, NUM_COLS_MAX - 1)),
                                     pick_value(), fin);
                    else
                        send_nonzero(row,
                                     COL_W'(legal_cols[$urandom_range(0, legal_cols.size() - 1)]),
                                     pick_value(), fin);
                end
                // Next row: mostly ascending, sometimes a jump, back down, or the same.
                r = $urandom_range(0, 99);
                if (r < 60)
                    row = row + ROW_W'($urandom_range(1, 3));
                else if (r < 80)
                    row = ROW_W'($urandom);
                else if (r < 90)
                    row = row - ROW_W'($urandom_range(1, 5));
            end
        end
        gaps_on = 1'b1;
    endtask

    // Test sequence.
    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        kind        = 1'b0;
        column      = '0;
        entry_row   = '0;
        value       = '0;
        final_entry = 1'b0;
        gaps_on     = 1'b1;
        items_sent   = 0;
        rows_checked = 0;
        cfg_writes   = 0;
        errors       = 0;
        cols_in_use  = 11'd1;
        row_acc      = 0;
        open_row     = '0;
        row_is_open  = 1'b0;
        acc_sat      = 1'b0;
        acc_bad      = 1'b0;
        foreach (vec_written[i])
        begin
            vec_written[i] = 1'b0;
            vec_shadow[i]  = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_config();
        test_extreme_values();
        test_special_cases();
        test_random_traffic();
        drain_results();

        $display("Covered %0d input transactions and %0d register writes, %0d row results checked.",
                 items_sent, cfg_writes, rows_checked);
        $display("Mismatches: %0d.", errors);
        if (errors == 0)
            $display("csr_sparse_matrix_vector_multiply_tb OK");
        else
            $display("csr_sparse_matrix_vector_multiply_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/csrmv_pkg.sv
design/csrmv_fifo.sv
design/csrmv_front.sv
design/csrmv_back.sv
design/csr_sparse_matrix_vector_multiply.sv
sim/csr_sparse_matrix_vector_multiply_tb.sv
